>>> rtl/lphm_pkg.sv
package lphm_pkg;

	localparam logic [1:0] KIND_GET   = 2'd0;
	localparam logic [1:0] KIND_PUT   = 2'd1;
	localparam logic [1:0] KIND_ERASE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam int CHAIN_W = 11;
	localparam logic [CHAIN_W-1:0] CHAIN_MAX = '1;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_EVAL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic               occ;
		logic [CHAIN_W-1:0] chain;
	} meta_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] hash;
		logic [31:0] value;
	} slot_t;

	// one reflected crc-32c byte step, eight bit steps
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/lphm_if.sv
interface lphm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [63:0]        key;
	logic signed [31:0] value;

	modport source (output valid, kind, key, value, input ready);
	modport sink (input valid, kind, key, value, output ready);
endinterface

interface lphm_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] value_read;
	logic [10:0]        entry_count;

	modport source (output valid, status, value_read, entry_count, input ready);
	modport sink (input valid, status, value_read, entry_count, output ready);
endinterface

>>> rtl/linear_probe_hash_map_unit.sv
// the key is hashed bytewise, then each probed slot is read and then evaluated; an erase that
// finds its key probes the slots before it a second time
// one transaction in flight; the probe loop through the slot memories sets the rate
// a result waits in the output register while the next transaction is taken
// reset: clears control state, then sweeps every entry of the slot status memory
// before the first transaction is accepted
module linear_probe_hash_map_unit #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	lphm_req_if.sink    req,
	lphm_rsp_if.source  rsp
);
	import lphm_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = SLOT_W + 1;
	localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);

	state_t state_q, state_d;

	logic [1:0]         kind_q;
	logic [63:0]        key_q;
	logic [31:0]        value_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   steps_q;
	logic               pass2_q;
	logic [CNT_W-1:0]   total_q;
	logic [SLOT_W-1:0]  clr_q;
	logic [1:0]         status_q;
	logic [31:0]        vread_q;

	logic               rsp_valid_q;
	logic [1:0]         rsp_status_q;
	logic [31:0]        rsp_vread_q;
	logic [10:0]        rsp_count_q;

	logic               hash_start, hash_done;
	logic [31:0]        hash;
	logic [SLOT_W-1:0]  idx;

	logic               meta_we;
	logic [SLOT_W-1:0]  meta_waddr;
	meta_t              meta_wdata, meta_rd;
	logic               data_we;
	slot_t              data_wdata, data_rd;

	// probe decisions
	logic               finish, go_pass2, inc_total, dec_total;
	logic [1:0]         fin_status;
	logic [31:0]        fin_vread;
	logic               full, accept, rsp_load;
	logic               occ, hit_h, hit, last;
	logic [31:0]        cnt_ext;

	assign idx      = hash[SLOT_W-1:0] + i_q[SLOT_W-1:0];
	assign full     = total_q == CNT_W'(CAPACITY);
	assign accept   = req.valid && req.ready;
	assign rsp_load = state_q == S_RESP && (!rsp_valid_q || rsp.ready);
	assign occ      = meta_rd.occ;
	assign hit_h    = occ && data_rd.hash == hash;
	assign hit      = hit_h && data_rd.key == key_q;
	assign last     = i_q == CNT_W'(CAPACITY - 1);

	// the hash starts on the accepting edge, so it takes the key straight from the request
	lphm_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.key & KEY_MASK),
		.done   (hash_done),
		.hash   (hash)
	);

	lphm_ram #(.WIDTH($bits(meta_t)), .DEPTH(CAPACITY)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (idx),
		.rdata (meta_rd)
	);

	lphm_ram #(.WIDTH($bits(slot_t)), .DEPTH(CAPACITY)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (idx),
		.wdata (data_wdata),
		.raddr (idx),
		.rdata (data_rd)
	);

	// evaluation of one probed slot, and the status memory sweep after reset
	always_comb begin
		finish     = 1'b0;
		go_pass2   = 1'b0;
		inc_total  = 1'b0;
		dec_total  = 1'b0;
		fin_status = ST_OK;
		fin_vread  = '0;
		meta_we    = 1'b0;
		meta_waddr = idx;
		meta_wdata = meta_rd;
		data_we    = 1'b0;
		data_wdata = '{key: key_q, hash: hash, value: value_q};
		if (state_q == S_CLEAR) begin
			meta_we    = 1'b1;
			meta_waddr = clr_q;
			meta_wdata = '0;
		end else if (state_q == S_EVAL) begin
			case (kind_q)
				KIND_GET: begin
					if (hit) begin
						finish    = 1'b1;
						fin_vread = data_rd.value;
					end else if ((!hit_h && meta_rd.chain == '0) || last) begin
						finish     = 1'b1;
						fin_status = ST_NOTFOUND;
					end
				end
				KIND_PUT: begin
					meta_we = 1'b1;
					if (!occ) begin
						meta_wdata.occ = 1'b1;
						data_we        = 1'b1;
						inc_total      = 1'b1;
						finish         = 1'b1;
					end else if (meta_rd.chain != CHAIN_MAX) begin
						meta_wdata.chain = meta_rd.chain + 1'b1;
					end
				end
				KIND_ERASE: begin
					if (pass2_q) begin
						meta_we = 1'b1;
						if (i_q == steps_q) begin
							meta_wdata.occ = 1'b0;
							dec_total      = total_q != '0;
							finish         = 1'b1;
						end else if (meta_rd.chain != '0) begin
							meta_wdata.chain = meta_rd.chain - 1'b1;
						end
					end else if (hit) begin
						go_pass2 = 1'b1;
					end else if (last) begin
						finish     = 1'b1;
						fin_status = ST_NOTFOUND;
					end
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == SLOT_W'(CAPACITY - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					state_d = (req.kind == KIND_GET || req.kind == KIND_PUT ||
						req.kind == KIND_ERASE) ? S_HASH : S_RESP;
				end
			end
			S_HASH: begin
				if (hash_done) begin
					state_d = (kind_q == KIND_PUT && full) ? S_RESP : S_READ;
				end
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: state_d = finish ? S_RESP : S_READ;
			S_RESP: if (rsp_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready  = state_q == S_IDLE;
		hash_start = 1'b0;
		if (state_q == S_IDLE && accept) begin
			hash_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			i_q         <= '0;
			pass2_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (inc_total) begin
				total_q <= total_q + 1'b1;
			end else if (dec_total) begin
				total_q <= total_q - 1'b1;
			end
			if (state_q == S_HASH) begin
				i_q     <= '0;
				pass2_q <= 1'b0;
			end else if (state_q == S_EVAL && !finish) begin
				if (go_pass2) begin
					i_q     <= '0;
					pass2_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req.kind;
			key_q    <= req.key & KEY_MASK;
			value_q  <= req.value;
			status_q <= ST_OK;
			vread_q  <= '0;
		end
		if (state_q == S_HASH && hash_done && kind_q == KIND_PUT && full) begin
			status_q <= ST_FULL;
		end
		if (state_q == S_EVAL) begin
			if (go_pass2) begin
				steps_q <= i_q;
			end
			if (finish) begin
				status_q <= fin_status;
				vread_q  <= fin_vread;
			end
		end
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_vread_q  <= vread_q;
			rsp_count_q  <= cnt_ext[10:0];
		end
	end

	assign cnt_ext = 32'(total_q);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.value_read  = rsp_vread_q;
	assign rsp.entry_count = rsp_count_q;
endmodule

>>> rtl/lphm_ram.sv
module lphm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/lphm_hash.sv
module lphm_hash #(
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic        done,
	output logic [31:0] hash
);
	import lphm_pkg::*;

	localparam int BC_W = $clog2(KEY_BYTES + 1);

	logic [BC_W-1:0] cnt_q;
	logic            done_q;
	logic [31:0]     crc_q;
	logic [63:0]     sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= BC_W'(KEY_BYTES);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BC_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// one byte per cycle, low byte first
	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= '0;
			sh_q  <= key;
		end else if (cnt_q != '0) begin
			crc_q <= crc_byte(crc_q, sh_q[7:0]);
			sh_q  <= sh_q >> 8;
		end
	end

	assign done = done_q;
	assign hash = crc_q;
endmodule
